>>> design/fcds_pkg.sv
// fcds_pkg: shared widths, register indexes, microcode ops, conditions and control structs
// for the fractional clock divider search; no dependencies
package fcds_pkg;

  localparam int unsigned BUS_W     = 28;
  localparam int unsigned BPS_W     = 6;
  localparam int unsigned RATE_W    = 20;
  localparam int unsigned SRC_W     = 27;
  localparam int unsigned DEN_W     = 27;
  localparam int unsigned N_W       = 8;
  localparam int unsigned B_W       = 6;
  localparam int unsigned QCNT_W    = 3;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned UPC_W     = 3;

  localparam logic [BUS_W-1:0] BUS_RESET = 28'd80000000;
  localparam logic [BPS_W-1:0] BPS_RESET = 6'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_BUS_CLOCK       = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BITS_PER_SAMPLE = 1'd1;

  localparam int unsigned DIV_LOW             = 2;
  localparam int unsigned DIV_HIGH            = 254;
  localparam int unsigned NUM_MAX             = 63;
  localparam int unsigned MAX_DENOMINATOR_DEF = 63;

  // sequencer steps
  localparam logic [UPC_W-1:0] STEP_WAIT  = 3'd0;
  localparam logic [UPC_W-1:0] STEP_SETUP = 3'd1;
  localparam logic [UPC_W-1:0] STEP_CHECK = 3'd2;
  localparam logic [UPC_W-1:0] STEP_DIV   = 3'd3;
  localparam logic [UPC_W-1:0] STEP_INIT  = 3'd4;
  localparam logic [UPC_W-1:0] STEP_CAND0 = 3'd5;
  localparam logic [UPC_W-1:0] STEP_CAND1 = 3'd6;
  localparam logic [UPC_W-1:0] STEP_PUT   = 3'd7;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_SETUP,
    OP_CHECK,
    OP_DIV,
    OP_INIT,
    OP_CAND0,
    OP_CAND1,
    OP_PUT
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_NO_WORD,
    C_BAD,
    C_DIV_MORE,
    C_MORE_A,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [UPC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic bad;
    logic div_more;
    logic more_a;
    logic out_busy;
  } stat_t;

endpackage

>>> design/fcds_rate_if.sv
// fcds_rate_if: valid/ready channel carrying one requested sample rate word
// depends on fcds_pkg
interface fcds_rate_if;
  logic                       valid;
  logic                       ready;
  logic [fcds_pkg::RATE_W-1:0] requested_rate;

  modport source (output valid, output requested_rate, input ready);
  modport sink   (input valid, input requested_rate, output ready);
endinterface

>>> design/fcds_div_if.sv
// fcds_div_if: valid/ready channel carrying one divider result word
// depends on fcds_pkg
interface fcds_div_if;
  logic                      valid;
  logic                      ready;
  logic                      status;
  logic [fcds_pkg::N_W-1:0]  divider_integer;
  logic [fcds_pkg::B_W-1:0]  fraction_numerator;
  logic [fcds_pkg::B_W-1:0]  fraction_denominator;

  modport source (output valid, output status, output divider_integer,
                  output fraction_numerator, output fraction_denominator, input ready);
  modport sink   (input valid, input status, input divider_integer,
                  input fraction_numerator, input fraction_denominator, output ready);
endinterface

>>> design/fcds_ucode.sv
// fcds_ucode: microcode rom, step counter and conditional jump logic
// depends on fcds_pkg
module fcds_ucode (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fcds_pkg::stat_t stat_i,
  output fcds_pkg::ctrl_t ctl_o
);

  logic [fcds_pkg::UPC_W-1:0] upc_q, upc_d;
  logic                       jump;

  // control store
  always_comb begin
    unique case (upc_q)
      fcds_pkg::STEP_WAIT:
        ctl_o = '{fcds_pkg::OP_LOAD,  fcds_pkg::C_NO_WORD,  fcds_pkg::STEP_WAIT};
      fcds_pkg::STEP_SETUP:
        ctl_o = '{fcds_pkg::OP_SETUP, fcds_pkg::C_NEVER,    fcds_pkg::STEP_WAIT};
      fcds_pkg::STEP_CHECK:
        ctl_o = '{fcds_pkg::OP_CHECK, fcds_pkg::C_BAD,      fcds_pkg::STEP_PUT};
      fcds_pkg::STEP_DIV:
        ctl_o = '{fcds_pkg::OP_DIV,   fcds_pkg::C_DIV_MORE, fcds_pkg::STEP_DIV};
      fcds_pkg::STEP_INIT:
        ctl_o = '{fcds_pkg::OP_INIT,  fcds_pkg::C_NEVER,    fcds_pkg::STEP_WAIT};
      fcds_pkg::STEP_CAND0:
        ctl_o = '{fcds_pkg::OP_CAND0, fcds_pkg::C_NEVER,    fcds_pkg::STEP_WAIT};
      fcds_pkg::STEP_CAND1:
        ctl_o = '{fcds_pkg::OP_CAND1, fcds_pkg::C_MORE_A,   fcds_pkg::STEP_CAND0};
      fcds_pkg::STEP_PUT:
        ctl_o = '{fcds_pkg::OP_PUT,   fcds_pkg::C_OUT_BUSY, fcds_pkg::STEP_PUT};
    endcase
  end

  always_comb begin
    unique case (ctl_o.cond)
      fcds_pkg::C_NO_WORD:  jump = !stat_i.in_valid;
      fcds_pkg::C_BAD:      jump = stat_i.bad;
      fcds_pkg::C_DIV_MORE: jump = stat_i.div_more;
      fcds_pkg::C_MORE_A:   jump = stat_i.more_a;
      fcds_pkg::C_OUT_BUSY: jump = stat_i.out_busy;
      default:              jump = 1'b0;
    endcase
  end

  // last step wraps back to wait
  assign upc_d = jump ? ctl_o.target : upc_q + fcds_pkg::UPC_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= fcds_pkg::STEP_WAIT;
    end else begin
      upc_q <= upc_d;
    end
  end

  a_put_to_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == fcds_pkg::STEP_PUT && !stat_i.out_busy) |=> upc_q == fcds_pkg::STEP_WAIT)
    else $error("put step did not return to wait");

  a_word_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == fcds_pkg::STEP_WAIT && stat_i.in_valid) |=> upc_q == fcds_pkg::STEP_SETUP)
    else $error("accepted word did not start setup");

  a_bad_skips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == fcds_pkg::STEP_CHECK && stat_i.bad) |=> upc_q == fcds_pkg::STEP_PUT)
    else $error("unsupported rate did not skip the search");

endmodule

>>> design/fcds_datapath.sv
// fcds_datapath: rate load, range check, bit-serial quotient, candidate compare and
// output register, driven by one control word per cycle; depends on fcds_pkg, fcds_*_if
module fcds_datapath #(
  parameter int unsigned MAX_DENOMINATOR = fcds_pkg::MAX_DENOMINATOR_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fcds_pkg::ctrl_t              ctl_i,
  output fcds_pkg::stat_t              stat_o,
  input  logic [fcds_pkg::BUS_W-1:0]   bus_clock_hz_i,
  input  logic [fcds_pkg::BPS_W-1:0]   bits_per_sample_i,
  fcds_rate_if.sink                    req_i,
  fcds_div_if.source                   res_o
);

  localparam int unsigned AW  = $clog2(MAX_DENOMINATOR + 1);
  localparam int unsigned DW  = fcds_pkg::DEN_W;
  localparam int unsigned SW  = fcds_pkg::SRC_W;
  localparam int unsigned NW  = fcds_pkg::N_W;
  localparam int unsigned BW  = fcds_pkg::B_W;
  localparam int unsigned LW  = DW + NW;
  localparam int unsigned PW  = DW + AW;
  localparam int unsigned XW  = AW + BW;

  logic [fcds_pkg::RATE_W-1:0] rate_q;
  logic [SW-1:0]               src_q;
  logic [DW-1:0]               den_q;
  logic                        fail_q;
  logic [SW-1:0]               rem_q;
  logic [LW-2:0]               dsh_q;
  logic [NW-1:0]               n_q;
  logic [fcds_pkg::QCNT_W-1:0] qcnt_q;
  logic [AW-1:0]               a_q;
  logic [AW-1:0]               b0_q;
  logic [DW-1:0]               acc_q;
  logic [DW-1:0]               best_e_q;
  logic [AW-1:0]               best_a_q;
  logic [BW-1:0]               best_b_q;

  logic                        out_valid_q;
  logic                        out_status_q;
  logic [NW-1:0]               out_n_q;
  logic [BW-1:0]               out_b_q;
  logic [BW-1:0]               out_a_q;

  logic [LW-1:0]               src_x, lim_lo, lim_hi;
  logic                        bad, div_fit, out_busy, more_a, is_c1, b_ok, better, wrap;
  logic [DW-1:0]               e_w;
  logic [XW-1:0]               b_w, a_x;
  logic [PW-1:0]               prod_new, prod_best;
  logic [DW:0]                 sum;

  // range check of the wanted divisor
  assign src_x  = LW'(src_q);
  assign lim_lo = LW'(den_q) * LW'(fcds_pkg::DIV_LOW);
  assign lim_hi = LW'(den_q) * LW'(fcds_pkg::DIV_HIGH);
  assign bad    = (den_q == '0) || (src_x < lim_lo) || (src_x >= lim_hi);

  assign div_fit = (LW-1)'(rem_q) >= dsh_q;

  // candidate error, floor or floor plus one
  assign is_c1     = (ctl_i.op == fcds_pkg::OP_CAND1);
  assign e_w       = is_c1 ? den_q - acc_q : acc_q;
  assign b_w       = is_c1 ? XW'(b0_q) + XW'(1) : XW'(b0_q);
  assign b_ok      = b_w <= XW'(fcds_pkg::NUM_MAX);
  assign prod_new  = PW'(e_w) * PW'(best_a_q);
  assign prod_best = PW'(best_e_q) * PW'(a_q);
  assign better    = b_ok && (prod_new < prod_best);

  assign sum  = (DW+1)'(acc_q) + (DW+1)'(rem_q);
  assign wrap = sum >= (DW+1)'(den_q);

  assign more_a   = a_q != AW'(MAX_DENOMINATOR);
  assign out_busy = out_valid_q && !res_o.ready;
  assign a_x      = XW'(best_a_q);

  assign stat_o.in_valid = req_i.valid;
  assign stat_o.bad      = bad;
  assign stat_o.div_more = qcnt_q != '0;
  assign stat_o.more_a   = more_a;
  assign stat_o.out_busy = out_busy;

  assign req_i.ready = (ctl_i.op == fcds_pkg::OP_LOAD);

  always_ff @(posedge clk_i) begin
    unique case (ctl_i.op)
      fcds_pkg::OP_LOAD: begin
        if (req_i.valid) begin
          rate_q <= req_i.requested_rate;
        end
      end
      fcds_pkg::OP_SETUP: begin
        src_q <= bus_clock_hz_i[fcds_pkg::BUS_W-1:1];
        den_q <= {(DW-1)'(rate_q) * (DW-1)'(bits_per_sample_i), 1'b0};
      end
      fcds_pkg::OP_CHECK: begin
        fail_q <= bad;
        rem_q  <= src_q;
        dsh_q  <= {den_q, (NW-1)'(0)};
        qcnt_q <= fcds_pkg::QCNT_W'(NW - 1);
      end
      fcds_pkg::OP_DIV: begin
        if (div_fit) begin
          rem_q <= rem_q - dsh_q[SW-1:0];
        end
        n_q    <= {n_q[NW-2:0], div_fit};
        dsh_q  <= dsh_q >> 1;
        qcnt_q <= qcnt_q - fcds_pkg::QCNT_W'(1);
      end
      fcds_pkg::OP_INIT: begin
        a_q      <= AW'(1);
        b0_q     <= '0;
        acc_q    <= rem_q;
        best_e_q <= den_q;
        best_a_q <= AW'(1);
        best_b_q <= '0;
      end
      fcds_pkg::OP_CAND0, fcds_pkg::OP_CAND1: begin
        if (better) begin
          best_e_q <= e_w;
          best_a_q <= a_q;
          best_b_q <= b_w[BW-1:0];
        end
        if (is_c1) begin
          a_q <= a_q + AW'(1);
          if (wrap) begin
            acc_q <= DW'(sum - (DW+1)'(den_q));
            b0_q  <= b0_q + AW'(1);
          end else begin
            acc_q <= DW'(sum);
          end
        end
      end
      fcds_pkg::OP_PUT: begin
        if (!out_busy) begin
          out_status_q <= fail_q;
          out_n_q      <= fail_q ? '0 : n_q;
          out_b_q      <= fail_q ? '0 : best_b_q;
          out_a_q      <= fail_q ? BW'(1) : a_x[BW-1:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.op == fcds_pkg::OP_PUT && !out_busy) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign res_o.valid                = out_valid_q;
  assign res_o.status               = out_status_q;
  assign res_o.divider_integer      = out_n_q;
  assign res_o.fraction_numerator   = out_b_q;
  assign res_o.fraction_denominator = out_a_q;

  a_acc_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.op == fcds_pkg::OP_CAND0 || ctl_i.op == fcds_pkg::OP_CAND1) |-> acc_q < den_q)
    else $error("search remainder not below frame divisor");

  a_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.op == fcds_pkg::OP_INIT) |->
      (n_q >= NW'(fcds_pkg::DIV_LOW) && n_q < NW'(fcds_pkg::DIV_HIGH)))
    else $error("integer divider out of range after division");

  a_best_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.op == fcds_pkg::OP_PUT && !fail_q) |-> best_e_q < den_q)
    else $error("search finished without a candidate");

endmodule

>>> design/fractional_clock_divider_search.sv
// an accepted word runs setup, a range check, a bit-serial integer quotient and then the
// candidate loop over each denominator up to MAX_DENOMINATOR; an unsupported rate skips to the result
// the candidate loop uses one compare unit, trying floor and floor plus one per denominator;
// a new word is taken only after the result has loaded, and loading waits while the output is held
// reset: bus clock 80 MHz, 16 bits per sample, sequencer waiting, output empty
module fractional_clock_divider_search #(
  parameter int unsigned MAX_DENOMINATOR = fcds_pkg::MAX_DENOMINATOR_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fcds_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [fcds_pkg::BUS_W-1:0]       cfg_data_i,
  fcds_rate_if.sink                        req_i,
  fcds_div_if.source                       res_o
);

  logic [fcds_pkg::BUS_W-1:0] bus_clock_hz_q;
  logic [fcds_pkg::BPS_W-1:0] bits_per_sample_q;
  fcds_pkg::ctrl_t            ctl;
  fcds_pkg::stat_t            stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_clock_hz_q    <= fcds_pkg::BUS_RESET;
      bits_per_sample_q <= fcds_pkg::BPS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fcds_pkg::CFG_BUS_CLOCK:       bus_clock_hz_q    <= cfg_data_i;
        fcds_pkg::CFG_BITS_PER_SAMPLE: bits_per_sample_q <= cfg_data_i[fcds_pkg::BPS_W-1:0];
      endcase
    end
  end

  fcds_ucode u_ucode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  fcds_datapath #(
    .MAX_DENOMINATOR (MAX_DENOMINATOR)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctl_i             (ctl),
    .stat_o            (stat),
    .bus_clock_hz_i    (bus_clock_hz_q),
    .bits_per_sample_i (bits_per_sample_q),
    .req_i             (req_i),
    .res_o             (res_o)
  );

endmodule
